// ===== hw/rtl/lrnac_pkg.sv =====
// shared types, register codes and power tables for the lrn block
package lrnac_pkg;

	localparam int MAX_CH    = 1024;
	localparam int MAX_HW    = 7;
	localparam int SQ_DEPTH  = 2 * MAX_HW + 1;
	localparam int DL_DEPTH  = MAX_HW + 1;
	localparam int POW_N     = 256;
	localparam int POW_BITS  = 8;
	localparam int QDEPTH    = 4;

	localparam logic [2:0] REG_CHANNEL_COUNT = 3'd0;
	localparam logic [2:0] REG_HALF_WINDOW   = 3'd1;
	localparam logic [2:0] REG_ALPHA         = 3'd2;
	localparam logic [2:0] REG_BETA          = 3'd3;
	localparam logic [2:0] REG_K_OFFSET      = 3'd4;

	localparam logic [63:0] ONE30 = 64'd1 << 30;

	typedef struct packed {
		logic signed [15:0] x;
		logic [35:0]        sum;
		logic [9:0]         chan;
		logic               lor;
		logic               lop;
	} job_t;

	typedef struct packed {
		logic [10:0] channel_count;
		logic [2:0]  half_window;
	} front_cfg_t;

	typedef struct packed {
		logic [31:0] alpha;
		logic [15:0] beta;
		logic [23:0] k;
	} back_cfg_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef logic [POW_N:0][16:0] log_tab_t;
	typedef logic [POW_N:0][31:0] exp_tab_t;

	// log2 of a q1.30 value in [1,2], q0.20 result, square-and-compare
	function automatic logic [63:0] log2_q20(input logic [63:0] yin);
		logic [63:0] y;
		logic [63:0] r;
		y = yin;
		r = 64'd0;
		if (y >= 2 * ONE30) return 64'd1 << 20;
		for (int b = 0; b < 20; b++) begin
			y = (y * y) >> 30;
			r = r << 1;
			if (y >= 2 * ONE30) begin
				r = r | 64'd1;
				y = y >> 1;
			end
		end
		return r;
	endfunction

	function automatic log_tab_t build_log_tab();
		log_tab_t    t;
		logic [63:0] jj;
		logic [63:0] y;
		for (int j = 0; j <= POW_N; j++) begin
			jj = 64'(j);
			y = ONE30 + (((jj << 30) + 64'(POW_N / 2)) / POW_N);
			t[j] = 17'((log2_q20(y) + 64'd8) >> 4);
		end
		return t;
	endfunction

	function automatic exp_tab_t build_exp_tab();
		exp_tab_t    t;
		logic [63:0] jj;
		logic [63:0] target;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] mid;
		for (int j = 0; j <= POW_N; j++) begin
			jj = 64'(j);
			target = ((jj << 20) + 64'(POW_N / 2)) / POW_N;
			lo = ONE30;
			hi = 2 * ONE30;
			while (lo < hi) begin
				mid = lo + (hi - lo + 64'd1) / 2;
				if (log2_q20(mid) <= target) lo = mid;
				else hi = mid - 64'd1;
			end
			t[j] = 32'(lo);
		end
		t[0] = 32'(ONE30);
		t[POW_N] = 32'(2 * ONE30);
		return t;
	endfunction

	localparam log_tab_t LOG_TAB = build_log_tab();
	localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

// ===== hw/rtl/lrnac_front.sv =====
// front end: window histories, window sums and job generation
module lrnac_front import lrnac_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] sample,
	input  front_cfg_t         cfg,
	input  q_status_t          qs,
	output logic               push,
	output job_t               job
);

	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_ACC  = 3'b010,
		F_EMIT = 3'b100
	} fstate_t;

	fstate_t            state_q;
	logic [10:0]        idx_q;
	logic [31:0]        sq_q [SQ_DEPTH];
	logic [15:0]        dl_q [DL_DEPTH];
	logic [35:0]        acc_q;
	logic [3:0]         k_q;
	logic [3:0]         kend_q;
	logic [2:0]         d_q;
	logic               last_q;
	logic [9:0]         i_q;

	logic [10:0]        cc_eff;
	logic [2:0]         hw_eff;
	logic               last_now;
	logic               has_job;
	logic [2:0]         d0;
	logic               accept;
	logic signed [31:0] sqr;

	always_comb begin
		if (cfg.channel_count == 11'd0) cc_eff = 11'd1;
		else if (cfg.channel_count > 11'(MAX_CH)) cc_eff = 11'(MAX_CH);
		else cc_eff = cfg.channel_count;
		hw_eff = (cfg.half_window > 3'(MAX_HW)) ? 3'(MAX_HW) : cfg.half_window;
		last_now = ({1'b0, idx_q} + 12'd1) >= {1'b0, cc_eff};
		has_job = last_now || ({8'd0, hw_eff} <= idx_q);
		d0 = ({8'd0, hw_eff} > idx_q) ? idx_q[2:0] : hw_eff;
		sqr = sample * sample;
	end

	assign in_stall = (state_q != F_IDLE);
	assign accept = in_valid && (state_q == F_IDLE);
	assign push = (state_q == F_EMIT) && !qs.full;

	always_comb begin
		job.x    = $signed(dl_q[d_q]);
		job.sum  = acc_q;
		job.chan = i_q - {7'd0, d_q};
		job.lor  = !last_q || (d_q == 3'd0);
		job.lop  = last_q && (d_q == 3'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			idx_q <= 11'd0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (accept) begin
						idx_q <= last_now ? 11'd0 : idx_q + 11'd1;
						if (has_job) state_q <= F_ACC;
					end
				end
				F_ACC: begin
					if (k_q == kend_q) state_q <= F_EMIT;
				end
				F_EMIT: begin
					if (push && (!last_q || d_q == 3'd0)) state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// histories restart empty at channel zero
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int k = 1; k < SQ_DEPTH; k++)
				sq_q[k] <= (idx_q == 11'd0) ? 32'd0 : sq_q[k-1];
			sq_q[0] <= $unsigned(sqr);
			for (int k = 1; k < DL_DEPTH; k++)
				dl_q[k] <= (idx_q == 11'd0) ? 16'd0 : dl_q[k-1];
			dl_q[0] <= $unsigned(sample);
			acc_q <= 36'd0;
			k_q <= 4'd0;
			kend_q <= {1'b0, d0} + {1'b0, hw_eff};
			d_q <= d0;
			last_q <= last_now;
			i_q <= idx_q[9:0];
		end else if (state_q == F_ACC) begin
			acc_q <= acc_q + {4'd0, sq_q[k_q]};
			if (k_q != kend_q) k_q <= k_q + 4'd1;
		end else if (push && last_q && d_q != 3'd0) begin
			// next narrower window drops its top square
			acc_q <= acc_q - {4'd0, sq_q[k_q]};
			k_q <= k_q - 4'd1;
			d_q <= d_q - 3'd1;
		end
	end

endmodule

// ===== hw/rtl/lrnac_queue.sv =====
// short job queue between front and back
module lrnac_queue import lrnac_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  job_t      push_job,
	input  logic      pop,
	output job_t      pop_job,
	output q_status_t qs
);

	localparam int PW = $clog2(QDEPTH);

	job_t          mem_q [QDEPTH];
	logic [PW-1:0] wp_q;
	logic [PW-1:0] rp_q;
	logic [PW:0]   cnt_q;

	assign qs.full  = (cnt_q == (PW+1)'(QDEPTH));
	assign qs.empty = (cnt_q == '0);
	assign pop_job  = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_job;
	end

endmodule

// ===== hw/rtl/lrnac_back.sv =====
// back end: power sequencer and result register
module lrnac_back import lrnac_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  back_cfg_t          cfg,
	input  q_status_t          qs,
	input  job_t               pop_job,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] out_sample,
	output logic [9:0]         out_channel,
	output logic               last_of_run,
	output logic               last_of_pixel
);

	typedef enum logic [11:0] {
		B_IDLE  = 12'b000000000001,
		B_MUL   = 12'b000000000010,
		B_BASE  = 12'b000000000100,
		B_NORM  = 12'b000000001000,
		B_LOG   = 12'b000000010000,
		B_LGA   = 12'b000000100000,
		B_POW   = 12'b000001000000,
		B_EXPM  = 12'b000010000000,
		B_EXPA  = 12'b000100000000,
		B_MAG   = 12'b001000000000,
		B_SCALE = 12'b010000000000,
		B_OUT   = 12'b100000000000
	} bstate_t;

	bstate_t            state_q;
	job_t               job_q;
	logic [35:0]        phi_q;
	logic [31:0]        plo_q;
	logic [36:0]        norm_q;
	logic [5:0]         lz_q;
	logic [46:0]        lprod_q;
	logic [16:0]        l0_q;
	logic signed [23:0] lg_q;
	logic signed [28:0] e_q;
	logic signed [12:0] ip_q;
	logic [47:0]        eprod_q;
	logic [31:0]        e0_q;
	logic [31:0]        ev_q;
	logic [47:0]        mag_q;
	logic signed [15:0] res_q;

	logic [63:0]        plo_full;
	logic [36:0]        base;
	logic signed [15:0] zero_res;
	logic [POW_BITS:0]  li;
	logic [16:0]        ldiff;
	logic [29:0]        lrem;
	logic [46:0]        lprod;
	logic [5:0]         p6;
	logic signed [7:0]  pm;
	logic signed [23:0] lg;
	logic signed [40:0] bprod;
	logic signed [40:0] earg;
	logic [15:0]        f;
	logic [POW_BITS:0]  ei;
	logic [31:0]        ediff;
	logic [47:0]        eprod;
	logic [16:0]        ax;
	logic [63:0]        v;
	logic [63:0]        rnd;
	logic signed [13:0] s_val;
	logic               big;
	logic signed [15:0] sc_res;

	assign pop = (state_q == B_IDLE) && !qs.empty;
	assign out_valid = (state_q == B_OUT);
	assign out_sample = res_q;
	assign out_channel = job_q.chan;
	assign last_of_run = job_q.lor;
	assign last_of_pixel = job_q.lop;

	always_comb begin
		plo_full = job_q.sum[31:0] * cfg.alpha;
		base = {13'd0, cfg.k} + {1'b0, phi_q} + {5'd0, plo_q};
		if (cfg.beta == 16'd0) zero_res = job_q.x;
		else if (job_q.x == 16'sd0) zero_res = 16'sd0;
		else if (job_q.x < 0) zero_res = -16'sd32768;
		else zero_res = 16'sd32767;

		li = {1'b0, norm_q[35 -: POW_BITS]};
		ldiff = LOG_TAB[li + 1'b1] - LOG_TAB[li];
		lrem = {norm_q[35-POW_BITS:6], {POW_BITS{1'b0}}};
		lprod = ldiff * lrem;

		p6 = 6'd36 - lz_q;
		pm = $signed({2'b0, p6}) - 8'sd16;
		lg = $signed({7'd0, l0_q}) + $signed({7'd0, lprod_q[46:30]})
			+ $signed({pm, 16'd0});

		bprod = $signed({1'b0, cfg.beta}) * lg_q;
		earg = (41'sd2048 - bprod) >>> 12;

		f = e_q[15:0];
		ei = {1'b0, f[15 -: POW_BITS]};
		ediff = EXP_TAB[ei + 1'b1] - EXP_TAB[ei];
		eprod = ediff * {f[15-POW_BITS:0], {POW_BITS{1'b0}}};

		ax = job_q.x[15] ? 17'(-$signed({job_q.x[15], job_q.x})) : {1'b0, job_q.x};

		// power of two scaling with half-up rounding
		v = 64'd0;
		rnd = 64'd0;
		big = 1'b0;
		s_val = 14'sd30 - $signed({ip_q[12], ip_q});
		if (ip_q >= 13'sd17) begin
			big = 1'b1;
		end else if (ip_q >= 13'sd0) begin
			v = {16'd0, mag_q} << ip_q[4:0];
			rnd = (v + (64'd1 << 29)) >> 30;
		end else if (s_val < 14'sd60) begin
			rnd = ({16'd0, mag_q} + (64'd1 << (s_val[5:0] - 6'd1))) >> s_val[5:0];
		end
		if (mag_q == 48'd0) sc_res = 16'sd0;
		else if (job_q.x[15]) begin
			if (big || rnd >= 64'd32768) sc_res = -16'sd32768;
			else sc_res = -$signed(rnd[15:0]);
		end else begin
			if (big || rnd > 64'd32767) sc_res = 16'sd32767;
			else sc_res = $signed(rnd[15:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			unique case (state_q)
				B_IDLE:  if (!qs.empty) state_q <= B_MUL;
				B_MUL:   state_q <= B_BASE;
				B_BASE:  state_q <= (base == 37'd0) ? B_OUT : B_NORM;
				B_NORM:  if (norm_q[36]) state_q <= B_LOG;
				B_LOG:   state_q <= B_LGA;
				B_LGA:   state_q <= B_POW;
				B_POW:   state_q <= B_EXPM;
				B_EXPM:  state_q <= B_EXPA;
				B_EXPA:  state_q <= B_MAG;
				B_MAG:   state_q <= B_SCALE;
				B_SCALE: state_q <= B_OUT;
				B_OUT:   if (!out_stall) state_q <= B_IDLE;
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: if (pop) job_q <= pop_job;
			B_MUL: begin
				phi_q <= {28'd0, job_q.sum[35:32]} * {4'd0, cfg.alpha};
				plo_q <= plo_full[63:32];
			end
			B_BASE: begin
				norm_q <= base;
				lz_q <= 6'd0;
				res_q <= zero_res;
			end
			B_NORM: begin
				// leading one search while the top is clear: eight bits at a time while the top eight bits are zero, else one bit
				if (!norm_q[36]) begin
					if (norm_q[36:29] == 8'd0) begin
						norm_q <= norm_q << 8;
						lz_q <= lz_q + 6'd8;
					end else begin
						norm_q <= norm_q << 1;
						lz_q <= lz_q + 6'd1;
					end
				end
			end
			B_LOG: begin
				lprod_q <= lprod;
				l0_q <= LOG_TAB[li];
			end
			B_LGA: lg_q <= lg;
			B_POW: e_q <= earg[28:0];
			B_EXPM: begin
				eprod_q <= eprod;
				e0_q <= EXP_TAB[ei];
				ip_q <= e_q[28:16];
			end
			B_EXPA: ev_q <= e0_q + eprod_q[47:16];
			B_MAG: mag_q <= ax[15:0] * ev_q;
			B_SCALE: res_q <= sc_res;
			B_OUT: ;
			default: ;
		endcase
	end

endmodule

// ===== hw/rtl/lrn_across_channels.sv =====
// top level of the cross-channel local response normalization block
// sequence: an item is taken, its window sum gathers up to 2*half_window+1 squares (fewer
//   near the pixel edges) and the emit state pushes its first job, waiting while the queue
//   is full; the back sequencer runs IDLE, MUL, BASE and OUT for a zero base, otherwise also
//   NORM (leading-one search), LOG, LGA, POW, EXPM, EXPA, MAG and SCALE, and takes the next
//   job only once its result leaves OUT; the front accepts a new sample once its
//   jobs are queued, and the last channel of a pixel queues up to half_window+1 jobs
// reset: asynchronous, active low; registers take their documented defaults, queue
//   empties, channel position returns to zero; histories clear at each pixel start
module lrn_across_channels import lrnac_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] sample,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] out_sample,
	output logic [9:0]         out_channel,
	output logic               last_of_run,
	output logic               last_of_pixel,
	input  logic               wr_en,
	input  logic [2:0]         wr_index,
	input  logic [31:0]        wr_data
);

	// configuration registers
	logic [10:0] channel_count_q;
	logic [2:0]  half_window_q;
	logic [31:0] alpha_q;
	logic [15:0] beta_q;
	logic [23:0] k_q;

	front_cfg_t fcfg;
	back_cfg_t  bcfg;
	q_status_t  qs;
	logic       push;
	logic       pop;
	job_t       push_job;
	job_t       pop_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_count_q <= 11'd64;
			half_window_q <= 3'd2;
			alpha_q <= 32'd85899;
			beta_q <= 16'd3072;
			k_q <= 24'd65536;
		end else if (wr_en) begin
			// unknown indexes are dropped
			unique case (wr_index)
				REG_CHANNEL_COUNT: channel_count_q <= wr_data[10:0];
				REG_HALF_WINDOW:   half_window_q <= wr_data[2:0];
				REG_ALPHA:         alpha_q <= wr_data;
				REG_BETA:          beta_q <= wr_data[15:0];
				REG_K_OFFSET:      k_q <= wr_data[23:0];
				default: ;
			endcase
		end
	end

	assign fcfg.channel_count = channel_count_q;
	assign fcfg.half_window = half_window_q;
	assign bcfg.alpha = alpha_q;
	assign bcfg.beta = beta_q;
	assign bcfg.k = k_q;

	// front: shifts squares and raw samples, builds window sums, queues one job per output
	lrnac_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sample   (sample),
		.cfg      (fcfg),
		.qs       (qs),
		.push     (push),
		.job      (push_job)
	);

	// queue lets the front keep taking beats while the back is busy
	lrnac_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.pop_job  (pop_job),
		.qs       (qs)
	);

	// back: base, then (unless the base is zero) log2, power, exp2 and scaling, then holds the result beat
	lrnac_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (bcfg),
		.qs            (qs),
		.pop_job       (pop_job),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_sample    (out_sample),
		.out_channel   (out_channel),
		.last_of_run   (last_of_run),
		.last_of_pixel (last_of_pixel)
	);

endmodule
